// ===== sv/short_key_interner_macros.svh =====
// ----------------------------------------------------------------------------
// short key interner assertion macros
// concurrent assertion shorthands shared by the checker
// ----------------------------------------------------------------------------
`ifndef SHORT_KEY_INTERNER_MACROS_SVH
`define SHORT_KEY_INTERNER_MACROS_SVH

// same-cycle implication, disabled in reset
`define SKI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define SKI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/ski_pkg.sv =====
// ----------------------------------------------------------------------------
// ski_pkg
// shared constants and control types of the short key interner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ski_pkg;

  // slot count, a power of two
  localparam int TABLE_SLOTS = 1024;
  localparam int IDX_W       = $clog2(TABLE_SLOTS);
  localparam int LEN_W       = 3;
  localparam int BYTES_W     = 32;
  localparam int KEY_W       = LEN_W + BYTES_W;
  localparam int ID_W        = 11;

  localparam logic [63:0] FIB_MULT = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [31:0] FIB_LO   = FIB_MULT[31:0];
  localparam logic [31:0] FIB_HI   = FIB_MULT[63:32];
  localparam int          HASH_SHIFT = 50;
  localparam int          HASH_LSB   = HASH_SHIFT - 32;

  localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(TABLE_SLOTS - 1);

  typedef struct packed {
    logic clear_en;
    logic load_in;
    logic calc_slot;
    logic read_en;
    logic step_slot;
    logic hit;
    logic insert;
    logic set_full;
    logic load_out;
  } ski_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic len_ok;
    logic act;
    logic key_match;
    logic slot_empty;
    logic probe_last;
  } ski_status_t;

endpackage

// ===== sv/ski_ram.sv =====
// ----------------------------------------------------------------------------
// ski_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ski_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ski_ctrl.sv =====
// ----------------------------------------------------------------------------
// ski_ctrl
// sequencer for clearing, hashing, probing and result hand-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ski_ctrl import ski_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  ski_status_t status_i,
  output ski_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_SUM    = 6'b000100,
    ST_READ   = 6'b001000,
    ST_CHECK  = 6'b010000,
    ST_FINISH = 6'b100000
  } ski_state_e;

  ski_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd_o.calc_slot = 1'b1;
        state_d         = status_i.len_ok ? ST_READ : ST_FINISH;
      end
      ST_READ: begin
        cmd_o.read_en = 1'b1;
        state_d       = ST_CHECK;
      end
      ST_CHECK: begin
        priority if (status_i.key_match) begin
          cmd_o.hit = 1'b1;
          state_d   = ST_FINISH;
        end else if (status_i.slot_empty) begin
          cmd_o.insert = status_i.act;
          state_d      = ST_FINISH;
        end else if (status_i.probe_last) begin
          cmd_o.set_full = status_i.act;
          state_d        = ST_FINISH;
        end else begin
          cmd_o.step_slot = 1'b1;
          state_d         = ST_READ;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/ski_dp.sv =====
// ----------------------------------------------------------------------------
// ski_dp
// key forming, fibonacci hash, slot stores, probe and result registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ski_dp import ski_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ski_cmd_t           cmd_i,
  output ski_status_t        status_o,
  input  logic               action_i,
  input  logic [LEN_W-1:0]   key_length_i,
  input  logic [BYTES_W-1:0] key_bytes_i,
  output logic [ID_W-1:0]    entry_id_o,
  output logic               was_present_o,
  output logic               table_full_o
);

  logic [BYTES_W-1:0] masked_bytes;
  logic               len_ok;
  logic [63:0]        prod_lo;
  logic [31:0]        prod_mid;
  logic [31:0]        prod_len;
  logic [31:0]        hash_sum;

  logic               act_q;
  logic               len_ok_q;
  logic [KEY_W-1:0]   key_q;
  logic [31:0]        p0_q, p1_q, p2_q;
  logic [IDX_W-1:0]   slot_q, slot_d;
  logic [IDX_W-1:0]   probe_q, probe_d;
  logic [IDX_W-1:0]   clr_q, clr_d;
  logic [ID_W-1:0]    next_id_q, next_id_d;
  logic [ID_W-1:0]    res_id_q;
  logic               res_present_q, res_full_q;
  logic [ID_W-1:0]    entry_id_q;
  logic               was_present_q, table_full_q;

  logic               key_we;
  logic [IDX_W-1:0]   key_waddr;
  logic [KEY_W-1:0]   key_wdata;
  logic [KEY_W-1:0]   key_rdata;
  logic [ID_W-1:0]    id_rdata;

  always_comb begin
    len_ok = 1'b1;
    unique case (key_length_i)
      3'd1:    masked_bytes = {24'd0, key_bytes_i[7:0]};
      3'd2:    masked_bytes = {16'd0, key_bytes_i[15:0]};
      3'd3:    masked_bytes = {8'd0, key_bytes_i[23:0]};
      3'd4:    masked_bytes = key_bytes_i;
      default: begin
        masked_bytes = '0;
        len_ok       = 1'b0;
      end
    endcase
  end

  // upper product word split into partial products
  assign prod_lo  = 64'(masked_bytes) * 64'(FIB_LO);
  assign prod_mid = masked_bytes * FIB_HI;
  assign prod_len = 32'(key_length_i) * FIB_LO;
  assign hash_sum = p0_q + p1_q + p2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      act_q    <= action_i;
      len_ok_q <= len_ok;
      key_q    <= {key_length_i, masked_bytes};
      p0_q     <= prod_lo[63:32];
      p1_q     <= prod_mid;
      p2_q     <= prod_len;
    end
    slot_q  <= slot_d;
    probe_q <= probe_d;
    if (cmd_i.load_in) begin
      res_id_q      <= '0;
      res_present_q <= 1'b0;
      res_full_q    <= 1'b0;
    end
    if (cmd_i.hit) begin
      res_id_q      <= id_rdata;
      res_present_q <= 1'b1;
    end
    if (cmd_i.insert) begin
      res_id_q <= next_id_q;
    end
    if (cmd_i.set_full) begin
      res_full_q <= 1'b1;
    end
    if (cmd_i.load_out) begin
      entry_id_q    <= res_id_q;
      was_present_q <= res_present_q;
      table_full_q  <= res_full_q;
    end
  end

  always_comb begin
    slot_d  = slot_q;
    probe_d = probe_q;
    if (cmd_i.calc_slot) begin
      slot_d  = hash_sum[HASH_LSB +: IDX_W];
      probe_d = '0;
    end else if (cmd_i.step_slot) begin
      slot_d  = slot_q + IDX_W'(1);
      probe_d = probe_q + IDX_W'(1);
    end
  end

  assign clr_d     = cmd_i.clear_en ? clr_q + IDX_W'(1) : clr_q;
  assign next_id_d = cmd_i.insert ? next_id_q + ID_W'(1) : next_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      next_id_q <= ID_W'(1);
    end else begin
      clr_q     <= clr_d;
      next_id_q <= next_id_d;
    end
  end

  assign key_we    = cmd_i.clear_en | cmd_i.insert;
  assign key_waddr = cmd_i.clear_en ? clr_q : slot_q;
  assign key_wdata = cmd_i.clear_en ? '0 : key_q;

  ski_ram #(
    .WIDTH(KEY_W),
    .DEPTH(TABLE_SLOTS)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(key_waddr),
    .wdata_i(key_wdata),
    .re_i   (cmd_i.read_en),
    .raddr_i(slot_q),
    .rdata_o(key_rdata)
  );

  ski_ram #(
    .WIDTH(ID_W),
    .DEPTH(TABLE_SLOTS)
  ) u_id_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.insert),
    .waddr_i(slot_q),
    .wdata_i(next_id_q),
    .re_i   (cmd_i.read_en),
    .raddr_i(slot_q),
    .rdata_o(id_rdata)
  );

  assign status_o.clear_last = (clr_q == SLOT_LAST);
  assign status_o.len_ok     = len_ok_q;
  assign status_o.act        = act_q;
  assign status_o.key_match  = (key_rdata == key_q);
  assign status_o.slot_empty = (key_rdata == '0);
  assign status_o.probe_last = (probe_q == SLOT_LAST);

  assign entry_id_o    = entry_id_q;
  assign was_present_o = was_present_q;
  assign table_full_o  = table_full_q;

endmodule

// ===== sv/short_key_interner.sv =====
// ----------------------------------------------------------------------------
// short_key_interner
// interns keys of one to four bytes in a linear probing hash table
// ----------------------------------------------------------------------------
// After reset the key store is swept clear, one slot a cycle, with in_ready_o
// low. One item is then handled at a time: an accepted item passes through a
// hash sum state, then one read and one compare state per probe, since every
// probe is a read of the key and id memories with registered data followed by
// a compare, and reaches the result register in the finish state, which waits
// while an earlier result is still pending; the next beat is accepted after
// that. A sparse table needs about one probe; a key of invalid length skips
// the probes. The result waits in an output register, so the next beat can be
// accepted while the previous result is still pending.
`timescale 1ns / 1ps

module short_key_interner import ski_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic [LEN_W-1:0]   key_length_i,
  input  logic [BYTES_W-1:0] key_bytes_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ID_W-1:0]    entry_id_o,
  output logic               was_present_o,
  output logic               table_full_o
);

  ski_cmd_t    cmd;
  ski_status_t status;

  ski_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ski_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .action_i     (action_i),
    .key_length_i (key_length_i),
    .key_bytes_i  (key_bytes_i),
    .entry_id_o   (entry_id_o),
    .was_present_o(was_present_o),
    .table_full_o (table_full_o)
  );

endmodule

// ===== sv/ski_checker.sv =====
// ----------------------------------------------------------------------------
// ski_checker
// port level checks of the short key interner, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "short_key_interner_macros.svh"

module ski_checker import ski_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic [ID_W-1:0] entry_id_o,
  input logic            was_present_o,
  input logic            table_full_o
);

  // a pending result beat holds
  `SKI_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(entry_id_o))

  // one item at a time
  `SKI_ASSERT_NXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // a full flag carries no id and no hit
  `SKI_ASSERT_IMP(a_full_zero, clk_i, rst_ni, out_valid_o && table_full_o, entry_id_o == '0 && !was_present_o)

  // stored ids are never zero
  `SKI_ASSERT_IMP(a_hit_id, clk_i, rst_ni, out_valid_o && was_present_o, entry_id_o != '0)

endmodule

bind short_key_interner ski_checker u_checker (.*);
